// ===== rtl/core/kalman_angle_bias_filter_assert.svh =====
// assertion macros for the kalman angle bias filter
// used by the top level only
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KAB_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define KAB_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define KAB_ASSERT_IMP(label, clk, rst, a, c)
`define KAB_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/kab_pkg.sv =====
// shared types and constants for the kalman angle bias filter
// no dependencies
`timescale 1ns / 1ps
package kab_pkg;
   localparam logic [1:0] CSR_DT = 2'd0;
   localparam logic [1:0] CSR_QA = 2'd1;
   localparam logic [1:0] CSR_QB = 2'd2;
   localparam logic [1:0] CSR_R  = 2'd3;
   localparam int CSR_IDX_W = 3;

   // datapath operations, one per controller step
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ANG_MUL, OP_ANG_ADD, OP_ERR,
      OP_P00_MUL, OP_P00_ADD, OP_P01_MUL, OP_P01_ADD,
      OP_P11_MUL, OP_P11_ADD, OP_DIV0_START, OP_DIV1_START,
      OP_K0P00_MUL, OP_K0P00_ADD, OP_K0P01_MUL, OP_K0P01_ADD,
      OP_K1P00_MUL, OP_K1P00_ADD, OP_K1P01_MUL, OP_K1P01_ADD,
      OP_K0E_MUL, OP_K0E_ADD, OP_K1E_MUL, OP_K1E_ADD, OP_RATE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      if (x < -66'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction
endpackage

// ===== rtl/core/kab_divider.sv =====
// restoring divider: 56-bit non-negative dividend magnitude by 33-bit divisor
// depends on kab_pkg for the saturate helper
`timescale 1ns / 1ps
module kab_divider import kab_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic        [32:0] den,
   output logic               busy,
   output logic signed [31:0] quo
);
   localparam int NB = 56;
   logic [5:0]   cnt_ff, cnt_in;
   logic [NB-1:0] q_ff, q_in;
   logic [33:0]  r_ff, r_in;
   logic         neg_ff, neg_in;
   logic         busy_ff, busy_in;
   logic signed [31:0] quo_ff, quo_in;
   logic [33:0]  trial;
   logic [NB:0]  qmag;

   // one quotient bit a cycle
   always_comb begin
      cnt_in = cnt_ff; q_in = q_ff; r_in = r_ff; neg_in = neg_ff;
      busy_in = busy_ff; quo_in = quo_ff;
      trial = {r_ff[32:0], q_ff[NB-1]};
      qmag = '0;
      if (start) begin
         neg_in = num[31];
         q_in = {(num[31] ? -{{24{num[31]}}, num} : {{24{1'b0}}, num})} << 24;
         r_in = '0; cnt_in = 6'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den}; q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            r_in = trial; q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            qmag = {1'b0, q_in};
            quo_in = neg_ff ? sat32(-$signed({9'b0, qmag})) : sat32($signed({9'b0, qmag}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; neg_ff <= neg_in; quo_ff <= quo_in;
   end
   assign busy = busy_ff;
   assign quo = quo_ff;
endmodule

// ===== rtl/core/kab_datapath.sv =====
// filter state, config registers, shared multiplier and rounding adder
// depends on kab_pkg and kab_divider
`timescale 1ns / 1ps
module kab_datapath import kab_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]        csr_data,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_gyro_rate,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_rate_estimate
);
   logic [15:0] dt_ff;
   logic [30:0] qa_ff, qb_ff, r_ff;
   logic signed [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] meas_ff, gyro_ff, err_ff, k0_ff, k1_ff, t0_ff, t1_ff;
   logic signed [31:0] out_ang_ff, out_rate_ff;
   logic signed [33:0] ma_ff;
   logic signed [33:0] ma;
   logic signed [32:0] mb;
   logic signed [32:0] mb_ff;
   logic signed [51:0] pp_lo_ff;
   logic signed [49:0] pp_hi_ff;
   logic signed [66:0] prod_ff;
   logic signed [31:0] addend;
   logic        [5:0]  sh;
   logic signed [66:0] rnd;
   logic signed [65:0] sum;
   logic signed [65:0] res;
   logic               div_start, div_busy;
   logic signed [31:0] div_num, quo;
   logic signed [32:0] e;
   logic               e_pos;

   assign e = $signed({2'b0, r_ff}) + p00_ff;
   assign e_pos = (e > 33'sd0);

   kab_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(e[32:0]), .busy(div_busy), .quo(quo)
   );
   assign sts.div_busy = div_busy;

   // multiplier operand select
   always_comb begin
      ma = '0; mb = '0;
      case (cmd.op)
         OP_ANG_MUL:   begin ma = 34'(gyro_ff) - 34'(bias_ff); mb = {17'b0, dt_ff}; end
         OP_P00_MUL:   begin
            ma = $signed({3'b0, qa_ff}) - 34'(p01_ff) - 34'(p10_ff);
            mb = {17'b0, dt_ff};
         end
         OP_P01_MUL:   begin ma = -34'(p11_ff); mb = {17'b0, dt_ff}; end
         OP_P11_MUL:   begin ma = $signed({3'b0, qb_ff}); mb = {17'b0, dt_ff}; end
         OP_K0P00_MUL: begin ma = 34'(k0_ff); mb = 33'(t0_ff); end
         OP_K0P01_MUL: begin ma = 34'(k0_ff); mb = 33'(t1_ff); end
         OP_K1P00_MUL: begin ma = 34'(k1_ff); mb = 33'(t0_ff); end
         OP_K1P01_MUL: begin ma = 34'(k1_ff); mb = 33'(t1_ff); end
         OP_K0E_MUL:   begin ma = 34'(k0_ff); mb = 33'(err_ff); end
         OP_K1E_MUL:   begin ma = 34'(k1_ff); mb = 33'(err_ff); end
         default: ;
      endcase
   end

   // rounding shift, then add to or subtract from the selected register
   always_comb begin
      addend = ang_ff; sh = 6'd16;
      case (cmd.op)
         OP_P00_ADD:   addend = p00_ff;
         OP_P01_ADD:   addend = p01_ff;
         OP_P11_ADD:   addend = p11_ff;
         OP_K0P00_ADD: begin addend = p00_ff; sh = 6'd24; end
         OP_K0P01_ADD: begin addend = p01_ff; sh = 6'd24; end
         OP_K1P00_ADD: begin addend = p10_ff; sh = 6'd24; end
         OP_K1P01_ADD: begin addend = p11_ff; sh = 6'd24; end
         OP_K0E_ADD:   begin addend = ang_ff; sh = 6'd24; end
         OP_K1E_ADD:   begin addend = bias_ff; sh = 6'd24; end
         default: ;
      endcase
      rnd = (prod_ff + (67'sd1 <<< (sh - 6'd1))) >>> sh;
      if (sh == 6'd24) sum = 66'(addend) - 66'(rnd);
      else sum = 66'(addend) + 66'(rnd);
      if (cmd.op == OP_K0E_ADD || cmd.op == OP_K1E_ADD) sum = 66'(addend) + 66'(rnd);
      res = sum;
   end

   assign div_start = (cmd.op == OP_DIV0_START) || (cmd.op == OP_DIV1_START);
   assign div_num = (cmd.op == OP_DIV1_START) ? p10_ff : p00_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= 16'd328; qa_ff <= 31'd16777; qb_ff <= 31'd83886;
         r_ff <= 31'd8388608;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= 32'sd16777216; p01_ff <= '0; p10_ff <= '0; p11_ff <= 32'sd16777216;
      end else begin
         // config words
         if (csr_write) begin
            unique case (csr_index)
               {1'b0, CSR_DT}: dt_ff <= csr_data[15:0];
               {1'b0, CSR_QA}: qa_ff <= csr_data;
               {1'b0, CSR_QB}: qb_ff <= csr_data;
               {1'b0, CSR_R}:  r_ff <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            OP_ANG_ADD:   ang_ff <= sat32(res);
            OP_P00_ADD:   p00_ff <= sat32(res);
            OP_P01_ADD:   begin p01_ff <= sat32(res); p10_ff <= sat32(66'(p10_ff) + res - 66'(p01_ff)); end
            OP_P11_ADD:   p11_ff <= sat32(res);
            OP_K0P00_ADD: p00_ff <= sat32(res);
            OP_K0P01_ADD: p01_ff <= sat32(res);
            OP_K1P00_ADD: p10_ff <= sat32(res);
            OP_K1P01_ADD: p11_ff <= sat32(res);
            OP_K0E_ADD:   ang_ff <= sat32(res);
            OP_K1E_ADD:   bias_ff <= sat32(res);
            default: ;
         endcase
      end
   end

   // three-stage multiply: operands, two partial products, sum
   always_ff @(posedge clock) begin
      ma_ff <= ma; mb_ff <= mb;
      pp_lo_ff <= 52'(ma_ff) * $signed({35'b0, mb_ff[16:0]});
      pp_hi_ff <= 50'(ma_ff) * 50'($signed(mb_ff[32:17]));
      prod_ff <= (67'(pp_hi_ff) <<< 17) + 67'(pp_lo_ff);
      case (cmd.op)
         OP_LOAD: begin meas_ff <= req_measured_angle; gyro_ff <= req_gyro_rate; end
         OP_ERR:  err_ff <= sat32(66'(meas_ff) - 66'(ang_ff));
         OP_DIV1_START: begin
            k0_ff <= e_pos ? quo : '0;
            t0_ff <= p00_ff; t1_ff <= p01_ff;
         end
         OP_K0P00_MUL: k1_ff <= e_pos ? quo : '0;
         OP_RATE: begin
            out_ang_ff <= ang_ff;
            out_rate_ff <= sat32(66'(gyro_ff) - 66'(bias_ff));
         end
         default: ;
      endcase
   end
   assign rsp_angle_estimate = out_ang_ff;
   assign rsp_rate_estimate = out_rate_ff;
endmodule

// ===== rtl/core/kab_control.sv =====
// sequencer stepping the datapath through one filter update
// depends on kab_pkg
`timescale 1ns / 1ps
module kab_control import kab_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_DIV0 = 3'd2,
                          S_DIV1 = 3'd3, S_OUT = 3'd4;
   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       vld_ff, vld_in;
   op_type     op;

   // step table: each add waits for its mul's product
   always_comb begin
      op = OP_NONE;
      case (step_ff)
         5'd0: op = OP_ANG_MUL;  5'd3: op = OP_ANG_ADD;  5'd4: op = OP_ERR;
         5'd5: op = OP_P00_MUL;  5'd8: op = OP_P00_ADD;
         5'd9: op = OP_P01_MUL;  5'd12: op = OP_P01_ADD;
         5'd13: op = OP_P11_MUL; 5'd16: op = OP_P11_ADD;
         default: op = OP_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff; step_in = step_ff; vld_in = vld_ff;
      cmd.op = OP_NONE;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && !vld_in) begin
            cmd.op = OP_LOAD; state_in = S_RUN; step_in = '0;
         end
         S_RUN: begin
            cmd.op = op; step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin state_in = S_DIV0; step_in = '0; end
         end
         S_DIV0: begin
            if (step_ff == 5'd0) begin cmd.op = OP_DIV0_START; step_in = 5'd1; end
            else if (step_ff == 5'd1) step_in = 5'd2;
            else if (!sts.div_busy) begin
               cmd.op = OP_DIV1_START; state_in = S_DIV1; step_in = 5'd1;
            end
         end
         S_DIV1: begin
            if (step_ff == 5'd1) step_in = 5'd2;
            else if (!sts.div_busy) begin state_in = S_OUT; step_in = '0; end
         end
         S_OUT: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd0: cmd.op = OP_K0P00_MUL;  5'd1: cmd.op = OP_K0P01_MUL;
               5'd2: cmd.op = OP_K1P00_MUL;
               5'd3: cmd.op = OP_K0P00_ADD;  5'd4: cmd.op = OP_K0P01_ADD;
               5'd5: cmd.op = OP_K1P00_ADD;  5'd6: cmd.op = OP_K1P01_MUL;
               5'd9: cmd.op = OP_K1P01_ADD;
               5'd10: cmd.op = OP_K0E_MUL;   5'd13: cmd.op = OP_K0E_ADD;
               5'd14: cmd.op = OP_K1E_MUL;   5'd17: cmd.op = OP_K1E_ADD;
               5'd18: cmd.op = OP_RATE;
               default: cmd.op = OP_NONE;
            endcase
            if (step_ff == 5'd18) begin state_in = S_IDLE; vld_in = 1'b1; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; vld_ff <= vld_in;
      end
   end
   assign req_ready = (state_ff == S_IDLE) && !(vld_ff && !rsp_ready);
   assign rsp_valid = vld_ff;
endmodule

// ===== rtl/core/kalman_angle_bias_filter.sv =====
// two-state kalman filter, angle and gyro bias; one word in, one word out
// each word runs 17 predict steps, two 56-step serial divisions with
// hand-off and 19 correct steps between accept and rsp_valid
// no new word is taken while one is in flight; the next word is
// taken once the result register is free
// synchronous active-high reset restores default config, zero state, identity covariance
`timescale 1ns / 1ps
`include "kalman_angle_bias_filter_assert.svh"
module kalman_angle_bias_filter import kab_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_gyro_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_rate_estimate,
   input  logic               csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]        csr_data
);
   cmd_type cmd;
   sts_type sts;

   kab_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts)
   );
   kab_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_measured_angle(req_measured_angle), .req_gyro_rate(req_gyro_rate),
      .rsp_angle_estimate(rsp_angle_estimate), .rsp_rate_estimate(rsp_rate_estimate)
   );

   `KAB_ASSERT_IMP(a_load_on_accept, clock, reset, req_valid && req_ready, cmd.op == OP_LOAD)
   `KAB_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_angle_estimate))
   `KAB_ASSERT_IMP(a_no_accept_div, clock, reset, sts.div_busy, !req_ready)
endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the two-state angle and gyro bias kalman filter
// depends on kab_pkg and the kalman_angle_bias_filter top level
`timescale 1ns / 1ps
module tb_top;
   import kab_pkg::*;

   localparam longint ONE_Q24 = 64'sd16777216;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int CSR_BAD_INDEX = 5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_measured_angle = '0;
   logic signed [31:0] req_gyro_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_angle_estimate;
   logic signed [31:0] rsp_rate_estimate;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [30:0] csr_data = '0;

   kalman_angle_bias_filter u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] gyro;
   } sample_t;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
   } estimate_t;

   // filter model state and registers
   longint m_dt, m_qa, m_qb, m_r, m_angle, m_bias;
   longint m_p[4];

   sample_t   sample_queue[$];
   estimate_t estimate_queue[$];
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // shift right rounding half up (floor after adding half an lsb)
   function automatic longint rnd_shift(longint x, int n);
      longint y;
      y = x + (64'sd1 <<< (n - 1));
      return y >>> n;
   endfunction

   task automatic model_reset();
      m_dt = 328; m_qa = 16777; m_qb = 83886; m_r = 8388608;
      m_angle = 0; m_bias = 0;
      m_p[0] = ONE_Q24; m_p[1] = 0; m_p[2] = 0; m_p[3] = ONE_Q24;
   endtask

   task automatic model_config(int idx, longint val);
      case (idx)
         CSR_DT: m_dt = val & 64'hffff;
         CSR_QA: m_qa = val & 64'h7fffffff;
         CSR_QB: m_qb = val & 64'h7fffffff;
         CSR_R:  m_r  = val & 64'h7fffffff;
         default: ;
      endcase
   endtask

   // one filter step: predict, gains, correct
   function automatic estimate_t filter_step(sample_t s);
      longint meas, gyro, rate, err, p00, p01, p10, p11, d0, e, k0, k1, t0, t1;
      estimate_t r;
      meas = s.angle;
      gyro = s.gyro;
      rate = gyro - m_bias;
      m_angle = clip32(m_angle + rnd_shift(rate * m_dt, 16));
      err = clip32(meas - m_angle);
      p00 = m_p[0]; p01 = m_p[1]; p10 = m_p[2]; p11 = m_p[3];
      d0 = m_qa - p01 - p10;
      p00 = clip32(p00 + rnd_shift(d0 * m_dt, 16));
      p01 = clip32(p01 + rnd_shift(-p11 * m_dt, 16));
      p10 = clip32(p10 + rnd_shift(-p11 * m_dt, 16));
      p11 = clip32(p11 + rnd_shift(m_qb * m_dt, 16));
      e = m_r + p00;
      if (e > 0) begin
         k0 = clip32((p00 * ONE_Q24) / e);
         k1 = clip32((p10 * ONE_Q24) / e);
      end else begin
         k0 = 0;
         k1 = 0;
      end
      t0 = p00;
      t1 = p01;
      m_p[0] = clip32(p00 - rnd_shift(k0 * t0, 24));
      m_p[1] = clip32(p01 - rnd_shift(k0 * t1, 24));
      m_p[2] = clip32(p10 - rnd_shift(k1 * t0, 24));
      m_p[3] = clip32(p11 - rnd_shift(k1 * t1, 24));
      m_angle = clip32(m_angle + rnd_shift(k0 * err, 24));
      m_bias = clip32(m_bias + rnd_shift(k1 * err, 24));
      r.angle = m_angle[31:0];
      r.rate = 32'(clip32(gyro - m_bias));
      return r;
   endfunction

   function automatic int pick_gap();
      int c;
      c = $urandom_range(0, 99);
      if (c < 40) return 0;
      if (c < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 300);
   endfunction

   // sample driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            estimate_queue.push_back(filter_step({req_measured_angle, req_gyro_rate}));
            words_in++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            sample_t s;
            s = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_measured_angle <= s.angle;
            req_gyro_rate <= s.gyro;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor with random back-pressure
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            estimate_t x;
            words_out++;
            if (estimate_queue.size() == 0) begin
               $error("unexpected result word angle=%0d rate=%0d",
                  rsp_angle_estimate, rsp_rate_estimate);
               errors++;
            end else begin
               x = estimate_queue.pop_front();
               if (rsp_angle_estimate !== x.angle) begin
                  $error("angle_estimate expected %0d got %0d", x.angle, rsp_angle_estimate);
                  errors++;
               end
               if (rsp_rate_estimate !== x.rate) begin
                  $error("rate_estimate expected %0d got %0d", x.rate, rsp_rate_estimate);
                  errors++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d words in, %0d out", words_in, words_out);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // write enable stays high across back-to-back writes, caller drops it
   task automatic csr_put(int idx, longint val);
      csr_write <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_data <= val[30:0];
      @(posedge clock);
      model_config(idx, val);
   endtask

   // wait until every sample is taken and every estimate is back
   task automatic drain();
      while (sample_queue.size() > 0 || req_valid || estimate_queue.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return 32'sh7fffffff;
      if (c == 1) return 32'sh80000000;
      if (c < 4) return $urandom;
      return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
   endfunction

   task automatic add_random(int n);
      sample_t s;
      repeat (n) begin
         s.angle = rand_word();
         s.gyro = rand_word();
         sample_queue.push_back(s);
      end
   endtask

   // phase settings: dt, qa, qb, r
   longint phase_cfg[6][4] = '{
      '{328, 16777, 83886, 8388608},
      '{65535, 2147483647, 2147483647, 2147483647},
      '{1, 0, 0, 1},
      '{0, 0, 0, 0},
      '{20000, 1000000, 5000, 100},
      '{1000, 16777, 83886, 2147483647}
   };

   initial begin
      sample_t s;
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, saturation of innovation and rate
      s = '{32'sh7fffffff, 32'sh7fffffff}; sample_queue.push_back(s);
      s = '{32'sh80000000, 32'sh80000000}; sample_queue.push_back(s);
      s = '{32'sh7fffffff, 32'sh80000000}; sample_queue.push_back(s);
      s = '{32'sh80000000, 32'sh7fffffff}; sample_queue.push_back(s);
      s = '{32'sh0, 32'sh0};               sample_queue.push_back(s);
      s = '{32'shffffffff, 32'sh1};        sample_queue.push_back(s);
      s = '{32'sh00010000, 32'shffff0000}; sample_queue.push_back(s);
      add_random(300);
      drain();

      for (int ph = 1; ph < 6; ph++) begin
         for (int i = 0; i < 4; i++) csr_put(i, phase_cfg[ph][i]);
         // write to an unused index should change nothing
         csr_put(CSR_BAD_INDEX, $urandom);
         csr_write <= 1'b0;
         if (ph == 2) begin
            s = '{32'sh7fffffff, 32'sh7fffffff}; sample_queue.push_back(s);
            s = '{32'sh80000000, 32'sh80000000}; sample_queue.push_back(s);
         end
         add_random(ph == 5 ? 400 : 250);
         drain();
      end

      stim_done = 1'b1;
      $display("covered %0d samples over 6 register settings incl. extremes", words_in);
      $display("%0d estimates checked, %0d mismatches", words_out, errors);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
